// ===== hw/rtl/quicksort_lomuto_last_pivot_assert.svh =====
// Assertion macros for the quicksort block checker.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef QUICKSORT_LOMUTO_LAST_PIVOT_ASSERT_SVH
`define QUICKSORT_LOMUTO_LAST_PIVOT_ASSERT_SVH

`define QLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define QLP_ASSERT_STABLE(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== hw/rtl/qlp_pkg.sv =====
// Shared types, constants and datapath command codes of the quicksort block.
// Used by the controller, the datapath, the top level and the checker.
package qlp_pkg;

  localparam int DEF_MAX_KEYS = 64;
  localparam int DEF_KEY_BITS = 32;
  localparam int KEY_FIELD_W  = 32;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic CFG_IDX_CMP_SIGNED = 1'b0;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] key_in;
    logic                   set_end;
  } in_item_t;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] key_out;
    logic                   run_end;
    logic                   overflowed;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_LD_RANGE,
    OP_LD_PIVOT,
    OP_RD_IS,
    OP_SWAP_A,
    OP_ADV_BOTH,
    OP_ADV_I,
    OP_WR_IB,
    OP_FIN,
    OP_FIN2,
    OP_PUSH1,
    OP_PUSH2,
    OP_CLR_I,
    OP_RD_K,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic count_lt2;
    logic sp_zero;
    logic i_eq_hi;
    logic less;
    logic i_gt_s;
    logic s_lt_hi;
    logic last_k;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/qlp_ctrl.sv =====
// Controller state machine of the quicksort block: load, partition, range stack, emit.
// Depends on qlp_pkg for the command codes and the status struct.
module qlp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_set_end_i,
  input  qlp_pkg::dp_stat_t  stat_i,
  output logic               in_ready_o,
  output qlp_pkg::dp_op_e    cmd_o
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_SWB   = 4'd7;
  localparam logic [3:0] S_FIN2  = 4'd8;
  localparam logic [3:0] S_PUSHA = 4'd9;
  localparam logic [3:0] S_PUSHB = 4'd10;
  localparam logic [3:0] S_OUTR  = 4'd11;
  localparam logic [3:0] S_OUTW  = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = qlp_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = qlp_pkg::OP_LOAD;
          if (in_set_end_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (stat_i.count_lt2) begin
          cmd_o   = qlp_pkg::OP_CLR_I;
          state_d = S_OUTR;
        end else begin
          cmd_o   = qlp_pkg::OP_INIT;
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (stat_i.sp_zero) begin
          cmd_o   = qlp_pkg::OP_CLR_I;
          state_d = S_OUTR;
        end else begin
          cmd_o   = qlp_pkg::OP_POP;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        cmd_o   = qlp_pkg::OP_LD_RANGE;
        state_d = S_PIV;
      end
      S_PIV: begin
        cmd_o   = qlp_pkg::OP_LD_PIVOT;
        state_d = S_RD;
      end
      S_RD: begin
        if (!stat_i.i_eq_hi) begin
          cmd_o   = qlp_pkg::OP_RD_IS;
          state_d = S_CMP;
        end else if (stat_i.s_lt_hi) begin
          cmd_o   = qlp_pkg::OP_FIN;
          state_d = S_FIN2;
        end else begin
          state_d = S_PUSHA;
        end
      end
      S_CMP: begin
        if (stat_i.less && stat_i.i_gt_s) begin
          cmd_o   = qlp_pkg::OP_SWAP_A;
          state_d = S_SWB;
        end else if (stat_i.less) begin
          cmd_o   = qlp_pkg::OP_ADV_BOTH;
          state_d = S_RD;
        end else begin
          cmd_o   = qlp_pkg::OP_ADV_I;
          state_d = S_RD;
        end
      end
      S_SWB: begin
        cmd_o   = qlp_pkg::OP_WR_IB;
        state_d = S_RD;
      end
      S_FIN2: begin
        cmd_o   = qlp_pkg::OP_FIN2;
        state_d = S_PUSHA;
      end
      S_PUSHA: begin
        cmd_o   = qlp_pkg::OP_PUSH1;
        state_d = S_PUSHB;
      end
      S_PUSHB: begin
        cmd_o   = qlp_pkg::OP_PUSH2;
        state_d = S_POP;
      end
      S_OUTR: begin
        cmd_o   = qlp_pkg::OP_RD_K;
        state_d = S_OUTW;
      end
      S_OUTW: begin
        if (stat_i.out_free) begin
          cmd_o   = qlp_pkg::OP_EMIT;
          state_d = stat_i.last_k ? S_LOAD : S_OUTR;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/qlp_dp.sv =====
// Datapath of the quicksort block: key memory, range stack memory, indices and result register.
// Depends on qlp_pkg; driven by qlp_ctrl through one command code per cycle.
module qlp_dp #(
  parameter int MAX_KEYS = qlp_pkg::DEF_MAX_KEYS,
  parameter int KEY_BITS = qlp_pkg::DEF_KEY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qlp_pkg::dp_op_e                  cmd_i,
  input  logic [qlp_pkg::KEY_FIELD_W-1:0]  in_key_i,
  input  logic                             cmp_signed_i,
  output qlp_pkg::dp_stat_t                stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output qlp_pkg::out_item_t               out_data_o
);

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int XW = (KEY_BITS > qlp_pkg::KEY_FIELD_W) ? KEY_BITS : qlp_pkg::KEY_FIELD_W;

  logic [KEY_BITS-1:0] key_mem [MAX_KEYS];
  logic [2*IW-1:0]     stk_mem [MAX_KEYS];

  logic [CW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CW-1:0]       sp_q, sp_d;
  logic                out_valid_q, out_valid_d;
  qlp_pkg::out_item_t  out_data_q, out_data_d;
  logic [IW-1:0]       lo_q, lo_d, hi_q, hi_d, i_q, i_d, s_q, s_d;
  logic [KEY_BITS-1:0] pivot_q, pivot_d;
  logic [KEY_BITS-1:0] rda_q, rdb_q;
  logic [2*IW-1:0]     stk_rd_q;

  logic                key_we, ra_en, rb_en, stk_we, stk_re;
  logic [IW-1:0]       key_waddr, ra_addr, rb_addr, stk_waddr, stk_raddr;
  logic [KEY_BITS-1:0] key_wdata;
  logic [2*IW-1:0]     stk_wdata;

  logic [XW-1:0]       key_ext, out_ext;
  logic [KEY_BITS-1:0] key_w, top_bit, cmp_a, cmp_b;
  logic [CW-1:0]       count_m1, sp_m1;
  logic                full, sp_full, last_k;
  logic [IW:0]         p_x, lo_x, hi_x;
  logic                left_ok, right_ok, left_first;
  logic [IW-1:0]       left_len, right_len;
  logic [2*IW-1:0]     left_rng, right_rng, push_rng;
  logic                push_ok;

  assign key_ext  = XW'(in_key_i);
  assign key_w    = key_ext[KEY_BITS-1:0];
  assign out_ext  = XW'(rda_q);
  assign count_m1 = count_q - CW'(1);
  assign sp_m1    = sp_q - CW'(1);
  assign full     = (count_q >= CW'(MAX_KEYS));
  assign sp_full  = (sp_q >= CW'(MAX_KEYS));
  assign last_k   = ((CW'(i_q) + CW'(1)) == count_q);

  assign top_bit = cmp_signed_i ? {1'b1, {(KEY_BITS-1){1'b0}}} : '0;
  assign cmp_a   = rda_q ^ top_bit;
  assign cmp_b   = pivot_q ^ top_bit;

  assign p_x        = {1'b0, s_q};
  assign lo_x       = {1'b0, lo_q};
  assign hi_x       = {1'b0, hi_q};
  assign left_ok    = (p_x > (lo_x + (IW+1)'(1)));
  assign right_ok   = ((p_x + (IW+1)'(1)) < hi_x);
  assign left_len   = (s_q > lo_q) ? (s_q - lo_q - IW'(1)) : '0;
  assign right_len  = (s_q < hi_q) ? (hi_q - s_q - IW'(1)) : '0;
  assign left_first = (left_len > right_len) || (s_q >= hi_q);
  assign left_rng   = {lo_q, s_q - IW'(1)};
  assign right_rng  = {s_q + IW'(1), hi_q};

  always_comb begin
    push_rng = left_first ? left_rng : right_rng;
    push_ok  = left_first ? left_ok : right_ok;
    if (cmd_i == qlp_pkg::OP_PUSH2) begin
      push_rng = left_first ? right_rng : left_rng;
      push_ok  = left_first ? right_ok : left_ok;
    end
  end

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    sp_d        = sp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    s_d         = s_q;
    pivot_d     = pivot_q;
    key_we      = 1'b0;
    key_waddr   = i_q;
    key_wdata   = rdb_q;
    ra_en       = 1'b0;
    ra_addr     = i_q;
    rb_en       = 1'b0;
    rb_addr     = s_q;
    stk_we      = 1'b0;
    stk_waddr   = sp_q[IW-1:0];
    stk_wdata   = push_rng;
    stk_re      = 1'b0;
    stk_raddr   = sp_m1[IW-1:0];
    case (cmd_i)
      qlp_pkg::OP_LOAD: begin
        if (!full) begin
          key_we    = 1'b1;
          key_waddr = count_q[IW-1:0];
          key_wdata = key_w;
          count_d   = count_q + CW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      qlp_pkg::OP_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {IW'(0), count_m1[IW-1:0]};
        sp_d      = CW'(1);
      end
      qlp_pkg::OP_POP: begin
        stk_re = 1'b1;
        sp_d   = sp_m1;
      end
      qlp_pkg::OP_LD_RANGE: begin
        lo_d    = stk_rd_q[2*IW-1:IW];
        hi_d    = stk_rd_q[IW-1:0];
        ra_en   = 1'b1;
        ra_addr = stk_rd_q[IW-1:0];
      end
      qlp_pkg::OP_LD_PIVOT: begin
        pivot_d = rda_q;
        i_d     = lo_q;
        s_d     = lo_q;
      end
      qlp_pkg::OP_RD_IS: begin
        ra_en = 1'b1;
        rb_en = 1'b1;
      end
      qlp_pkg::OP_SWAP_A: begin
        key_we    = 1'b1;
        key_waddr = s_q;
        key_wdata = rda_q;
        s_d       = s_q + IW'(1);
      end
      qlp_pkg::OP_ADV_BOTH: begin
        s_d = s_q + IW'(1);
        i_d = i_q + IW'(1);
      end
      qlp_pkg::OP_ADV_I: begin
        i_d = i_q + IW'(1);
      end
      qlp_pkg::OP_WR_IB: begin
        key_we = 1'b1;
        i_d    = i_q + IW'(1);
      end
      qlp_pkg::OP_FIN: begin
        rb_en     = 1'b1;
        key_we    = 1'b1;
        key_waddr = s_q;
        key_wdata = pivot_q;
      end
      qlp_pkg::OP_FIN2: begin
        key_we    = 1'b1;
        key_waddr = hi_q;
      end
      qlp_pkg::OP_PUSH1, qlp_pkg::OP_PUSH2: begin
        if (push_ok && !sp_full) begin
          stk_we = 1'b1;
          sp_d   = sp_q + CW'(1);
        end
      end
      qlp_pkg::OP_CLR_I: begin
        i_d = '0;
      end
      qlp_pkg::OP_RD_K: begin
        ra_en = 1'b1;
      end
      qlp_pkg::OP_EMIT: begin
        out_valid_d           = 1'b1;
        out_data_d.key_out    = out_ext[qlp_pkg::KEY_FIELD_W-1:0];
        out_data_d.run_end    = last_k;
        out_data_d.overflowed = ovf_q;
        if (last_k) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (ra_en) begin
      rda_q <= key_mem[ra_addr];
    end
    if (rb_en) begin
      rdb_q <= key_mem[rb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    i_q        <= i_d;
    s_q        <= s_d;
    pivot_q    <= pivot_d;
  end

  assign stat_o.count_lt2 = (count_q < CW'(2));
  assign stat_o.sp_zero   = (sp_q == '0);
  assign stat_o.i_eq_hi   = (i_q == hi_q);
  assign stat_o.less      = (cmp_a < cmp_b);
  assign stat_o.i_gt_s    = (i_q > s_q);
  assign stat_o.s_lt_hi   = (s_q < hi_q);
  assign stat_o.last_k    = last_k;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/quicksort_lomuto_last_pivot.sv =====
// Keys are taken while loading, with in_ready held high until the key that ends the set; a
// single-key set skips sorting. Each compared key is read and then compared, a swap adds a
// write back, and each range is popped, loaded and its pivot read; emitting reads each key
// and waits for a free result slot. The compare loop dominates; ordered or all-equal sets are slow.
// Reset is asynchronous and active low; it clears the controller, counts, stack pointer, compare
// mode and result valid. The key and range memories are not cleared and hold no reset value.
module quicksort_lomuto_last_pivot #(
  parameter int MAX_KEYS = qlp_pkg::DEF_MAX_KEYS,
  parameter int KEY_BITS = qlp_pkg::DEF_KEY_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  qlp_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output qlp_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qlp_pkg::APB_AW-1:0]   paddr,
  input  logic [qlp_pkg::APB_DW-1:0]   pwdata,
  output logic [qlp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  logic              cmp_signed_q, cmp_signed_d;
  logic              cfg_hit;
  qlp_pkg::dp_op_e   cmd;
  qlp_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[qlp_pkg::APB_AW-1:2] == qlp_pkg::CFG_IDX_CMP_SIGNED);

  always_comb begin
    cmp_signed_d = cmp_signed_q;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      cmp_signed_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_signed_q <= 1'b0;
    end else begin
      cmp_signed_q <= cmp_signed_d;
    end
  end

  assign prdata = cfg_hit ? {{(qlp_pkg::APB_DW-1){1'b0}}, cmp_signed_q} : '0;

  qlp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_set_end_i (in_data_i.set_end),
    .stat_i       (stat),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd)
  );

  qlp_dp #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_key_i     (in_data_i.key_in),
    .cmp_signed_i (cmp_signed_q),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hw/rtl/qlp_chk.sv =====
// Port-level checker for the quicksort block, bound to the top level below.
// Depends on qlp_pkg and the assertion macros in quicksort_lomuto_last_pivot_assert.svh.
`include "quicksort_lomuto_last_pivot_assert.svh"

module qlp_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input qlp_pkg::out_item_t          out_data_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [qlp_pkg::APB_AW-1:0]  paddr,
  input logic [qlp_pkg::APB_DW-1:0]  pwdata,
  input logic [qlp_pkg::APB_DW-1:0]  prdata,
  input logic                        pready
);

  `QLP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `QLP_ASSERT_STABLE(a_out_stable, out_valid_o && !out_ready_i, out_data_o, "stalled result changed")
  `QLP_ASSERT(a_no_load_mid_run, out_valid_o && !out_data_o.run_end |-> !in_ready_o, "key taken mid run")
  `QLP_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && (paddr[2] == qlp_pkg::CFG_IDX_CMP_SIGNED) |=> (paddr[2] != qlp_pkg::CFG_IDX_CMP_SIGNED) || (prdata[0] == $past(pwdata[0])), "compare mode readback mismatch")

endmodule

bind quicksort_lomuto_last_pivot qlp_chk u_qlp_chk (.*);
